// ===== rtl/core/msgs_pkg.sv =====
`default_nettype none

package msgs_pkg;

    localparam int HEIGHT_BITS = 32;
    localparam int DIFF_BITS   = HEIGHT_BITS + 1;
    localparam int WEIGHT_BITS = 48;
    localparam int LANES       = 6;
    localparam int SLOPES      = 8;
    localparam int ROOT_STAGES = 32;
    localparam int QUOT_BITS   = 47;
    localparam int REM_BITS    = QUOT_BITS + 16;
    localparam int SUM_BITS    = WEIGHT_BITS + 3;

    localparam logic [63:0] SLOPE_LIMIT  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] WEIGHT_LIMIT = 64'h0000_7FFF_FFFF_FFFF;

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_STEP_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_STEP_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_Y_OVER_X = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_X_OVER_Y = 3'd3;

    localparam logic [31:0] RST_INV_STEP = 32'd65536;
    localparam logic [31:0] RST_RATIO    = 32'd16777216;

    typedef struct packed {
        logic                                valid;
        logic                                clip;
        logic [LANES-1:0][WEIGHT_BITS-1:0]   w;
        logic [LANES-1:0][63:0]              rsum;
    } t_front;

    typedef struct packed {
        logic                                valid;
        logic                                clip;
        logic [LANES-1:0][WEIGHT_BITS-1:0]   w;
        logic [LANES-1:0][31:0]              root;
    } t_root;

    typedef struct packed {
        logic                                valid;
        logic                                clip;
        logic [LANES-1:0][WEIGHT_BITS-1:0]   term;
    } t_term;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [QUOT_BITS-1:0] q;
    } t_div;

    // one digit of the bitwise integer square root
    function automatic t_sqrt sqrt_step(input logic [63:0] x, input logic [63:0] res,
                                        input int unsigned sh);
        t_sqrt       o;
        logic [63:0] bitv;
        logic [63:0] trial;
        bitv  = 64'(1) << sh;
        trial = res + bitv;
        if (x >= trial) begin
            o.x   = x - trial;
            o.res = (res >> 1) + bitv;
        end else begin
            o.x   = x;
            o.res = res >> 1;
        end
        return o;
    endfunction

    // one quotient bit of restoring division
    function automatic t_div div_step(input logic [REM_BITS-1:0] rem,
                                      input logic [QUOT_BITS-1:0] q,
                                      input logic [31:0] f, input int unsigned i);
        t_div o;
        o.rem = rem;
        o.q   = q;
        if ((rem >> i) >= REM_BITS'(f)) begin
            o.rem = rem - (REM_BITS'(f) << i);
            o.q   = q | (QUOT_BITS'(1) << i);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msgs_front.sv =====
`default_nettype none

module msgs_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_adv,
    input  logic                                     i_accept,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]  i_center_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]  i_left_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]  i_right_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]  i_top_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]  i_bottom_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]  i_left_top_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]  i_right_bottom_height,
    input  logic [31:0]                              i_inv_step_x,
    input  logic [31:0]                              i_inv_step_y,
    input  logic [31:0]                              i_ratio_y_over_x,
    input  logic [31:0]                              i_ratio_x_over_y,
    output msgs_pkg::t_front                         o_front
);

    localparam int HB = msgs_pkg::HEIGHT_BITS;
    localparam int DW = msgs_pkg::DIFF_BITS;
    localparam int PW = DW + 32;
    localparam int WB = msgs_pkg::WEIGHT_BITS;
    localparam int NS = msgs_pkg::SLOPES;
    localparam int NL = msgs_pkg::LANES;

    function automatic logic signed [DW-1:0] sx(input logic signed [HB-1:0] v);
        return DW'(v);
    endfunction

    function automatic logic signed [WB-1:0] clip_sum(input logic signed [WB-1:0] a,
                                                      input logic signed [WB-1:0] b,
                                                      output logic hit);
        logic signed [WB:0] s;
        s   = (WB+1)'(a) + (WB+1)'(b);
        hit = 1'b0;
        if (s > $signed((WB+1)'(msgs_pkg::WEIGHT_LIMIT))) begin
            hit = 1'b1;
            return WB'(msgs_pkg::WEIGHT_LIMIT);
        end
        if (s < -$signed((WB+1)'(msgs_pkg::WEIGHT_LIMIT))) begin
            hit = 1'b1;
            return -$signed(WB'(msgs_pkg::WEIGHT_LIMIT));
        end
        return WB'(s);
    endfunction

    // differences
    logic                 r_a_valid;
    logic signed [DW-1:0] r_diff [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_diff[0] <= sx(i_center_height) - sx(i_left_height);
            r_diff[1] <= sx(i_center_height) - sx(i_right_height);
            r_diff[2] <= sx(i_center_height) - sx(i_top_height);
            r_diff[3] <= sx(i_center_height) - sx(i_bottom_height);
            r_diff[4] <= sx(i_right_height) - sx(i_right_bottom_height);
            r_diff[5] <= sx(i_right_bottom_height) - sx(i_bottom_height);
            r_diff[6] <= sx(i_left_top_height) - sx(i_left_height);
            r_diff[7] <= sx(i_top_height) - sx(i_left_top_height);
        end
    end

    // magnitude products
    logic [DW-1:0] mag [NS];
    logic [31:0]   ks  [NS];
    logic [31:0]   kw  [4];
    logic [2:0]    widx [4];

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            mag[i] = r_diff[i][DW-1] ? DW'(-r_diff[i]) : DW'(r_diff[i]);
        end
        ks[0] = i_inv_step_x;
        ks[1] = i_inv_step_x;
        ks[2] = i_inv_step_y;
        ks[3] = i_inv_step_y;
        ks[4] = i_inv_step_y;
        ks[5] = i_inv_step_x;
        ks[6] = i_inv_step_y;
        ks[7] = i_inv_step_x;
        widx[0] = 3'd0;
        widx[1] = 3'd3;
        widx[2] = 3'd2;
        widx[3] = 3'd1;
        kw[0] = i_ratio_y_over_x;
        kw[1] = i_ratio_x_over_y;
        kw[2] = i_ratio_x_over_y;
        kw[3] = i_ratio_y_over_x;
    end

    logic          r_b_valid;
    logic [PW-1:0] r_ps [NS];
    logic [PW-1:0] r_pw [4];
    logic          r_sgn_w [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < NS; i++) begin
                r_ps[i] <= PW'(mag[i]) * PW'(ks[i]);
            end
            for (int j = 0; j < 4; j++) begin
                r_pw[j]    <= PW'(mag[widx[j]]) * PW'(kw[j]);
                r_sgn_w[j] <= r_diff[widx[j]][DW-1];
            end
        end
    end

    // shift and clip
    logic [63:0]          vs [NS];
    logic [63:0]          vw [4];
    logic [30:0]          sm [NS];
    logic signed [WB-1:0] pv [4];
    logic                 clip_c;

    always_comb begin
        clip_c = 1'b0;
        for (int i = 0; i < NS; i++) begin
            vs[i] = 64'(r_ps[i][PW-1:24]);
            if (vs[i] > msgs_pkg::SLOPE_LIMIT) begin
                clip_c = 1'b1;
                sm[i]  = msgs_pkg::SLOPE_LIMIT[30:0];
            end else begin
                sm[i]  = vs[i][30:0];
            end
        end
        for (int j = 0; j < 4; j++) begin
            vw[j] = 64'(r_pw[j][PW-1:24]);
            if (vw[j] > msgs_pkg::WEIGHT_LIMIT) begin
                clip_c = 1'b1;
                vw[j]  = msgs_pkg::WEIGHT_LIMIT;
            end
            pv[j] = r_sgn_w[j] ? -$signed(WB'(vw[j])) : $signed(WB'(vw[j]));
        end
    end

    logic                 r_c_valid;
    logic                 r_c_clip;
    logic [30:0]          r_sm [NS];
    logic signed [WB-1:0] r_p  [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_clip <= clip_c;
            for (int i = 0; i < NS; i++) begin
                r_sm[i] <= sm[i];
            end
            for (int j = 0; j < 4; j++) begin
                r_p[j] <= pv[j];
            end
        end
    end

    // squares and weight sums
    logic signed [WB-1:0] w2;
    logic signed [WB-1:0] w4;
    logic                 hit2;
    logic                 hit4;

    always_comb begin
        w2 = clip_sum(r_p[0], r_p[1], hit2);
        w4 = clip_sum(r_p[3], r_p[2], hit4);
    end

    logic          r_d_valid;
    logic          r_d_clip;
    logic [61:0]   r_sq [NS];
    logic [WB-1:0] r_w  [NL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_clip <= r_c_clip | hit2 | hit4;
            for (int i = 0; i < NS; i++) begin
                r_sq[i] <= 62'(r_sm[i]) * 62'(r_sm[i]);
            end
            r_w[0] <= r_p[0];
            r_w[1] <= w2;
            r_w[2] <= r_p[2];
            r_w[3] <= w4;
            r_w[4] <= r_p[3];
            r_w[5] <= r_p[1];
        end
    end

    // root arguments: 1 + a^2 + b^2 in Q32.32
    logic                              r_e_valid;
    logic                              r_e_clip;
    logic [NL-1:0][WB-1:0]             r_e_w;
    logic [NL-1:0][63:0]               r_e_rsum;
    logic [2:0] ra [NL];
    logic [2:0] rb [NL];

    always_comb begin
        ra[0] = 3'd0; rb[0] = 3'd6;
        ra[1] = 3'd0; rb[1] = 3'd3;
        ra[2] = 3'd2; rb[2] = 3'd7;
        ra[3] = 3'd2; rb[3] = 3'd1;
        ra[4] = 3'd1; rb[4] = 3'd4;
        ra[5] = 3'd3; rb[5] = 3'd5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_adv) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_e_clip <= r_d_clip;
            for (int k = 0; k < NL; k++) begin
                r_e_w[k]    <= r_w[k];
                r_e_rsum[k] <= (64'(1) << 32) + 64'(r_sq[ra[k]]) + 64'(r_sq[rb[k]]);
            end
        end
    end

    assign o_front = '{valid: r_e_valid, clip: r_e_clip, w: r_e_w, rsum: r_e_rsum};

endmodule

`default_nettype wire

// ===== rtl/core/msgs_isqrt.sv =====
`default_nettype none

module msgs_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  msgs_pkg::t_front  i_front,
    output msgs_pkg::t_root   o_root
);

    localparam int NS = msgs_pkg::ROOT_STAGES;
    localparam int NL = msgs_pkg::LANES;
    localparam int WB = msgs_pkg::WEIGHT_BITS;

    logic          r_v [NS];
    logic          r_c [NS];
    logic [63:0]   r_x [NS][NL];
    logic [63:0]   r_r [NS][NL];
    logic [WB-1:0] r_w [NS][NL];

    msgs_pkg::t_sqrt st0 [NL];
    msgs_pkg::t_sqrt stn [NS-1][NL];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            st0[k] = msgs_pkg::sqrt_step(i_front.rsum[k], 64'd0, 62);
        end
        for (int s = 0; s < NS - 1; s++) begin
            for (int k = 0; k < NL; k++) begin
                stn[s][k] = msgs_pkg::sqrt_step(r_x[s][k], r_r[s][k], 60 - 2 * s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_front.valid;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // one root bit per stage, weights ride along
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c[0] <= i_front.clip;
            for (int k = 0; k < NL; k++) begin
                r_x[0][k] <= st0[k].x;
                r_r[0][k] <= st0[k].res;
                r_w[0][k] <= i_front.w[k];
            end
            for (int s = 1; s < NS; s++) begin
                r_c[s] <= r_c[s-1];
                for (int k = 0; k < NL; k++) begin
                    r_x[s][k] <= stn[s-1][k].x;
                    r_r[s][k] <= stn[s-1][k].res;
                    r_w[s][k] <= r_w[s-1][k];
                end
            end
        end
    end

    always_comb begin
        o_root.valid = r_v[NS-1];
        o_root.clip  = r_c[NS-1];
        for (int k = 0; k < NL; k++) begin
            o_root.w[k]    = r_w[NS-1][k];
            o_root.root[k] = r_r[NS-1][k][31:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/msgs_div.sv =====
`default_nettype none

module msgs_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  msgs_pkg::t_root  i_root,
    output msgs_pkg::t_term  o_term
);

    localparam int NQ = msgs_pkg::QUOT_BITS;
    localparam int RB = msgs_pkg::REM_BITS;
    localparam int NL = msgs_pkg::LANES;
    localparam int WB = msgs_pkg::WEIGHT_BITS;

    logic          r_v   [NQ];
    logic          r_c   [NQ];
    logic [RB-1:0] r_rem [NQ][NL];
    logic [NQ-1:0] r_q   [NQ][NL];
    logic [31:0]   r_f   [NQ][NL];
    logic          r_s   [NQ][NL];

    logic [NQ-1:0]   wmag [NL];
    msgs_pkg::t_div  dt0  [NL];
    msgs_pkg::t_div  dtn  [NQ-1][NL];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            wmag[k] = i_root.w[k][WB-1] ? NQ'(-i_root.w[k]) : NQ'(i_root.w[k]);
            dt0[k]  = msgs_pkg::div_step({wmag[k], 16'd0}, NQ'(0),
                                         i_root.root[k], NQ - 1);
        end
        for (int s = 0; s < NQ - 1; s++) begin
            for (int k = 0; k < NL; k++) begin
                dtn[s][k] = msgs_pkg::div_step(r_rem[s][k], r_q[s][k], r_f[s][k],
                                               NQ - 2 - s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NQ; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_root.valid;
            for (int s = 1; s < NQ; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // one quotient bit per stage, msb first
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c[0] <= i_root.clip;
            for (int k = 0; k < NL; k++) begin
                r_rem[0][k] <= dt0[k].rem;
                r_q[0][k]   <= dt0[k].q;
                r_f[0][k]   <= i_root.root[k];
                r_s[0][k]   <= i_root.w[k][WB-1];
            end
            for (int s = 1; s < NQ; s++) begin
                r_c[s] <= r_c[s-1];
                for (int k = 0; k < NL; k++) begin
                    r_rem[s][k] <= dtn[s-1][k].rem;
                    r_q[s][k]   <= dtn[s-1][k].q;
                    r_f[s][k]   <= r_f[s-1][k];
                    r_s[s][k]   <= r_s[s-1][k];
                end
            end
        end
    end

    always_comb begin
        o_term.valid = r_v[NQ-1];
        o_term.clip  = r_c[NQ-1];
        for (int k = 0; k < NL; k++) begin
            o_term.term[k] = r_s[NQ-1][k] ? WB'(-WB'(r_q[NQ-1][k])) : WB'(r_q[NQ-1][k]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/msgs_back.sv =====
`default_nettype none

module msgs_back (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_adv,
    input  msgs_pkg::t_term                          i_term,
    output logic                                     o_out_valid,
    output logic signed [msgs_pkg::HEIGHT_BITS-1:0]  o_gradient,
    output logic                                     o_saturated
);

    localparam int HB = msgs_pkg::HEIGHT_BITS;
    localparam int SB = msgs_pkg::SUM_BITS;
    localparam int WB = msgs_pkg::WEIGHT_BITS;
    localparam int NL = msgs_pkg::LANES;
    localparam logic signed [63:0] GMAX = (64'sd1 <<< (HB - 1)) - 64'sd1;
    localparam logic signed [63:0] GMIN = -GMAX - 64'sd1;

    logic signed [SB-1:0] sum;

    always_comb begin
        sum = '0;
        for (int k = 0; k < NL; k++) begin
            sum = sum + SB'($signed(i_term.term[k][WB-1:0]));
        end
    end

    logic                 r_s_valid;
    logic                 r_s_clip;
    logic signed [SB-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (i_adv) begin
            r_s_valid <= i_term.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum    <= sum;
            r_s_clip <= i_term.clip;
        end
    end

    // halve toward zero, then saturate
    logic signed [SB-1:0] biased;
    logic signed [63:0]   g64;
    logic signed [HB-1:0] g_sat;
    logic                 hit;

    always_comb begin
        biased = r_sum + $signed({{(SB-1){1'b0}}, r_sum[SB-1]});
        g64    = 64'(biased >>> 1);
        hit    = 1'b0;
        g_sat  = HB'(g64);
        if (g64 > GMAX) begin
            g_sat = HB'(GMAX);
            hit   = 1'b1;
        end else if (g64 < GMIN) begin
            g_sat = HB'(GMIN);
            hit   = 1'b1;
        end
    end

    logic                 r_out_valid;
    logic signed [HB-1:0] r_gradient;
    logic                 r_saturated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_gradient  <= g_sat;
            r_saturated <= r_s_clip | hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gradient  = r_gradient;
    assign o_saturated = r_saturated;

endmodule

`default_nettype wire

// ===== rtl/core/minimal_surface_gradient_stencil_unit.sv =====
// minimal-surface area gradient at one grid point per item
// input channel: i_in_valid / o_in_ready with the seven stencil heights, signed Q8.24;
//   edge points must already carry boundary values
// output channel: o_out_valid / i_out_ready with o_gradient (Q8.24, saturated) and
//   o_saturated, set when any slope, weight or the final value was clipped
// config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects inv_step_x,
//   inv_step_y, ratio_y_over_x, ratio_x_over_y; other indexes are dropped;
//   o_cfg_ready is always high; write only while no item is in flight
// throughput: one item per cycle, sustained
// latency: 86 cycles from accept to o_out_valid: 5 front stages (differences,
//   products, clip, squares, root sums), 32 square-root stages at one root bit
//   each, 47 divider stages at one quotient bit each, sum and output register
// the whole pipeline advances together; when the receiver holds i_out_ready low
//   with a result waiting, o_in_ready drops and every stage holds its item
// reset (synchronous, active low) empties the pipeline and restores unit
//   spacings and ratios
`default_nettype none

module minimal_surface_gradient_stencil_unit (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]       i_center_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]       i_left_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]       i_right_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]       i_top_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]       i_bottom_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]       i_left_top_height,
    input  logic signed [msgs_pkg::HEIGHT_BITS-1:0]       i_right_bottom_height,
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [msgs_pkg::CFG_INDEX_BITS-1:0]           i_cfg_index,
    input  logic [31:0]                                   i_cfg_data,
    output logic                                          o_out_valid,
    input  logic                                          i_out_ready,
    output logic signed [msgs_pkg::HEIGHT_BITS-1:0]       o_gradient,
    output logic                                          o_saturated
);

    logic [31:0] r_inv_step_x;
    logic [31:0] r_inv_step_y;
    logic [31:0] r_ratio_y_over_x;
    logic [31:0] r_ratio_x_over_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_step_x     <= msgs_pkg::RST_INV_STEP;
            r_inv_step_y     <= msgs_pkg::RST_INV_STEP;
            r_ratio_y_over_x <= msgs_pkg::RST_RATIO;
            r_ratio_x_over_y <= msgs_pkg::RST_RATIO;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                msgs_pkg::REG_INV_STEP_X:     r_inv_step_x     <= i_cfg_data;
                msgs_pkg::REG_INV_STEP_Y:     r_inv_step_y     <= i_cfg_data;
                msgs_pkg::REG_RATIO_Y_OVER_X: r_ratio_y_over_x <= i_cfg_data;
                msgs_pkg::REG_RATIO_X_OVER_Y: r_ratio_x_over_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic adv;
    logic accept;
    logic out_valid;

    assign adv        = !out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    msgs_pkg::t_front front;
    msgs_pkg::t_root  root;
    msgs_pkg::t_term  term;

    msgs_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_adv                 (adv),
        .i_accept              (accept),
        .i_center_height       (i_center_height),
        .i_left_height         (i_left_height),
        .i_right_height        (i_right_height),
        .i_top_height          (i_top_height),
        .i_bottom_height       (i_bottom_height),
        .i_left_top_height     (i_left_top_height),
        .i_right_bottom_height (i_right_bottom_height),
        .i_inv_step_x          (r_inv_step_x),
        .i_inv_step_y          (r_inv_step_y),
        .i_ratio_y_over_x      (r_ratio_y_over_x),
        .i_ratio_x_over_y      (r_ratio_x_over_y),
        .o_front               (front)
    );

    msgs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_front (front),
        .o_root  (root)
    );

    msgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_root  (root),
        .o_term  (term)
    );

    msgs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_term      (term),
        .o_out_valid (out_valid),
        .o_gradient  (o_gradient),
        .o_saturated (o_saturated)
    );

    assign o_out_valid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/msgs_checker.sv =====
`default_nettype none

module msgs_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_in_ready,
    input  logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    input  logic [msgs_pkg::HEIGHT_BITS-1:0]       o_gradient,
    input  logic                                   o_saturated
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // a free output slot always lets an item in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // a stalled result stalls the whole pipe
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("item taken while output stalled");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before accept");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_gradient) && $stable(o_saturated)))
        else $error("result changed while stalled");

endmodule

bind minimal_surface_gradient_stencil_unit msgs_checker u_msgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_gradient  (o_gradient),
    .o_saturated (o_saturated)
);

`default_nettype wire
